[hdl/tcw_pkg.sv]
// Package for the text mode console writer: transfer payload types,
// item kinds, character codes and the cursor command struct.
// No dependencies.
package tcw_pkg;

	localparam int COL_W = 7;
	localparam int ROW_W = 5;

	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [7:0] CH_CR       = 8'd13;
	localparam logic [7:0] CH_LF       = 8'd10;
	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] COLOR_RESET = 8'h0F;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} in_item_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [15:0] cell_value;
	} out_item_t;

	typedef struct packed {
		logic       put;
		logic       clear;
		logic [7:0] code;
	} cur_cmd_t;

endpackage

[hdl/tcw_cursor.sv]
// Cursor registers of the console writer: column and row update for
// put and clear, scroll detection and the linear cursor address.
// Depends on tcw_pkg.
module tcw_cursor import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cur_cmd_t      cmd,
	output logic [AW-1:0] pos,
	output logic          scroll
);

	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic             last_row, last_col, is_cr, is_lf;

	always_comb begin
		last_row = row_q == ROW_W'(ROWS - 1);
		last_col = col_q == COL_W'(COLUMNS - 1);
		is_cr    = cmd.code == CH_CR;
		is_lf    = cmd.code == CH_LF;
		scroll   = cmd.put && last_row && (is_lf || (!is_cr && last_col));
		pos      = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
		col_d    = col_q;
		row_d    = row_q;
		if (cmd.clear) begin
			col_d = '0;
			row_d = '0;
		end else if (cmd.put) begin
			if (is_cr) begin
				col_d = '0;
			end else if (is_lf) begin
				if (last_row) begin
					col_d = '0;
				end else begin
					row_d = row_q + ROW_W'(1);
				end
			end else if (last_col) begin
				col_d = '0;
				if (!last_row) begin
					row_d = row_q + ROW_W'(1);
				end
			end else begin
				col_d = col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule

[hdl/tcw_seq.sv]
// Sequencer of the console writer: cell memory, the shared address
// counter that walks it for scroll and clear, and the result register.
// Depends on tcw_pkg.
module tcw_seq import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    text_color,
	input  logic          in_valid,
	output logic          in_stall,
	input  in_item_t      in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output out_item_t     out_data,
	output cur_cmd_t      cmd,
	input  logic [AW-1:0] pos,
	input  logic          scroll
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam logic [AW-1:0] COPY_LAST = AW'(CELL_COUNT - COLUMNS - 1);
	localparam logic [AW-1:0] CELL_LAST = AW'(CELL_COUNT - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_COPY,
		S_BLANK,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   ptr_q, ptr_inc, rd_addr;
	logic            wv_s1, wrd_s1;
	logic [AW-1:0]   wa_s1;
	logic [15:0]     wd_s1, val_q, rdata_q, blank;
	logic            out_valid_q, out_free, idx_ok, printable;
	out_item_t       out_q;
	logic [15:0]     mem [CELL_COUNT];

	always_comb begin
		in_stall  = state_q != S_IDLE;
		out_valid = out_valid_q;
		out_data  = out_q;
		out_free  = !out_valid_q || !out_stall;
		blank     = {text_color, CH_SPACE};
		ptr_inc   = ptr_q + AW'(1);
		idx_ok    = {21'd0, in_data.cell_index} < 32'(CELL_COUNT);
		printable = in_data.char_code != CH_CR && in_data.char_code != CH_LF;
		rd_addr   = (state_q == S_COPY) ? ptr_q + AW'(COLUMNS) : AW'(in_data.cell_index);
		cmd.put   = in_valid && state_q == S_IDLE && in_data.kind == KIND_PUT;
		cmd.clear = in_valid && state_q == S_IDLE && in_data.kind == KIND_CLEAR;
		cmd.code  = in_data.char_code;
	end

	always_ff @(posedge clk) begin
		if (wv_s1) begin
			mem[wa_s1] <= wrd_s1 ? rdata_q : wd_s1;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			wv_s1       <= 1'b0;
			wrd_s1      <= 1'b0;
			wa_s1       <= '0;
			wd_s1       <= '0;
			val_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			wv_s1  <= (cmd.put && printable) || state_q == S_COPY || state_q == S_BLANK;
			wrd_s1 <= state_q == S_COPY;
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						val_q <= '0;
						ptr_q <= '0;
						case (in_data.kind)
							KIND_PUT: begin
								if (printable) begin
									wa_s1 <= pos;
									wd_s1 <= {text_color, in_data.char_code};
								end
								state_q <= scroll ? S_COPY : S_DONE;
							end
							KIND_CLEAR: state_q <= S_BLANK;
							KIND_READ:  state_q <= idx_ok ? S_READ : S_DONE;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_READ: begin
					val_q   <= rdata_q;
					state_q <= S_DONE;
				end
				S_COPY: begin
					wa_s1  <= ptr_q;
					ptr_q  <= ptr_inc;
					if (ptr_q == COPY_LAST) begin
						state_q <= S_BLANK;
					end
				end
				S_BLANK: begin
					wa_s1 <= ptr_q;
					wd_s1 <= blank;
					ptr_q <= ptr_inc;
					if (ptr_q == CELL_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q.cursor_pos <= 11'(pos);
						out_q.cell_value <= val_q;
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/text_mode_console_writer_top.sv]
// Top level of the text mode console writer: attribute register,
// cursor and sequencer instances, assertions.
// Depends on tcw_pkg, tcw_cursor and tcw_seq.

// Text-mode console of COLUMNS x ROWS 16-bit cells (attribute high byte,
// character low byte). One item at a time: a put or an out-of-range read
// goes through the done state to the result register, a cell read through
// the read and done states; a clear or a scrolling put first walks the
// single-write-port cell memory with the address counter, one cell a cycle.
// The result register lets a new item in while the previous result waits.
// Cells read before they were ever written return undefined data; there is
// no clearing pass after reset. Write text_color only while idle.
module text_mode_console_writer_top import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW = $clog2(CELL_COUNT);

	logic [7:0]    color_q;
	cur_cmd_t      cmd;
	logic [AW-1:0] pos;
	logic          scroll;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	tcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.AW(AW)
	) u_cursor (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.pos(pos),
		.scroll(scroll)
	);

	tcw_seq #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.AW(AW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.text_color(color_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cmd(cmd),
		.pos(pos),
		.scroll(scroll)
	);

`ifndef SYNTHESIS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without an item in progress");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> 32'(pos) < CELL_COUNT)
		else $error("cursor outside the screen");
`endif

endmodule
